@@ rtl/ptwr_pkg.sv @@
// Shared types and constants for the pulse train width recorder.
package ptwr_pkg;

    localparam int MAX_PULSES_DEF = 32;

    // Field widths fixed by the interface
    localparam int TIME_W  = 32;
    localparam int NUM_W   = 6;
    localparam int TMO_W   = 16;
    localparam int TPU_W   = 8;
    localparam int CFG_D_W = 16;
    localparam int CFG_I_W = 1;

    // Configuration register indexes
    localparam logic [CFG_I_W-1:0] CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic [CFG_I_W-1:0] CFG_TICK_RATE    = 1'b1;

    // Configuration reset values
    localparam logic [TMO_W-1:0] TMO_RST = 16'd1000;
    localparam logic [TPU_W-1:0] TPU_RST = 8'd84;

    // Input operation codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Restoring divider: one quotient bit per cycle over a 33-bit dividend
    localparam int DIVD_W    = TIME_W + 1;
    localparam int DIV_STEPS = DIVD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD_HI,
        S_DIV_HI,
        S_LOAD_LO,
        S_DIV_LO,
        S_PUSH
    } t_state;

endpackage

@@ rtl/ptwr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ptwr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/pulse_train_width_recorder.sv @@
// Top level of the pulse train width recorder: edge capture, idle timeout and train report.
// The block takes one transaction per input: an edge transaction (op 0) stores a high or low
// width, the wrapping difference of capture times, into two pulse RAMs and completes without
// raising o_stall; a tick transaction (op 1) that finds no finished train does the same.
// A tick that sees at least one pulse held and an idle time (now_ms minus the time of
// the last edge) at or above idle_timeout_ms starts the report of the whole train: the pulse
// count and the started flag clear at once, and each pulse then passes through one RAM read,
// one load, 33 steps of the shared bit-serial divider for the high width, one load, 33 steps
// for the low width and a hand-off of the result to the output register, which waits while
// the output side stalls. The single restoring divider yields one quotient bit per cycle, and
// o_stall stays high for the whole report. Widths are rounded to the nearest microsecond with
// halves rounded up; a tick rate of 0 divides by 1. Results leave through
// an output register, so the last result of a train may still wait while the next input
// transaction is taken. Pulse RAM contents need no clearing after reset.
module pulse_train_width_recorder #(
    parameter int MAX_PULSES = ptwr_pkg::MAX_PULSES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [ptwr_pkg::TIME_W-1:0]   i_capture_time,
    input  logic                          i_pin_level,
    input  logic [ptwr_pkg::TIME_W-1:0]   i_now_ms,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ptwr_pkg::NUM_W-1:0]    o_pulse_number,
    output logic [ptwr_pkg::TIME_W-1:0]   o_high_us,
    output logic [ptwr_pkg::TIME_W-1:0]   o_low_us,
    output logic [ptwr_pkg::NUM_W-1:0]    o_total_pulses,
    output logic                          o_last,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ptwr_pkg::CFG_I_W-1:0]  i_cfg_index,
    input  logic [ptwr_pkg::CFG_D_W-1:0]  i_cfg_data
);
    import ptwr_pkg::*;

    // Count holds 0..MAX_PULSES; the RAM address only 0..MAX_PULSES-1
    localparam int CW = $clog2(MAX_PULSES + 1);
    localparam int AW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;

    // Control state
    t_state            r_state, n_state;
    logic              r_first_seen, n_first_seen;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_total, n_total;
    logic [CW-1:0]     r_idx, n_idx;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic [TIME_W-1:0] r_last_capture, n_last_capture;
    logic [TIME_W-1:0] r_last_event_ms, n_last_event_ms;
    logic [TMO_W-1:0]  r_timeout, n_timeout;
    logic [TPU_W-1:0]  r_ticks, n_ticks;

    // Datapath
    logic [DIVD_W-1:0] r_dividend, n_dividend;
    logic [TPU_W-1:0]  r_rem, n_rem;
    logic [TIME_W-1:0] r_q_hi, n_q_hi;
    logic [NUM_W-1:0]  r_out_num, n_out_num;
    logic [TIME_W-1:0] r_out_high, n_out_high;
    logic [TIME_W-1:0] r_out_low, n_out_low;
    logic [NUM_W-1:0]  r_out_total, n_out_total;
    logic              r_out_last, n_out_last;

    // Pulse RAM ports
    logic              w_hi_we, w_lo_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [TIME_W-1:0] w_width;
    logic [TIME_W-1:0] w_hi_rdata, w_lo_rdata;

    // Helpers
    logic              w_in_acc;
    logic              w_room;
    logic [TIME_W-1:0] w_idle;
    logic              w_dump;
    logic [TPU_W-1:0]  w_div;
    logic [TPU_W-1:0]  w_half;
    logic [TPU_W:0]    w_trial;
    logic [TPU_W:0]    w_diff;
    logic              w_ge;
    logic [TPU_W-1:0]  w_rem_next;
    logic [31:0]       w_num32;
    logic [31:0]       w_tot32;
    logic              w_is_last;

    assign w_in_acc = i_valid && (r_state == S_IDLE);
    assign w_width  = i_capture_time - r_last_capture;
    assign w_room   = r_count < CW'(MAX_PULSES);
    assign w_idle   = i_now_ms - r_last_event_ms;
    assign w_dump   = (r_count != '0) && (w_idle >= TIME_W'(r_timeout));
    assign w_waddr  = r_count[AW-1:0];
    assign w_raddr  = r_idx[AW-1:0];

    // Shared divider step: a zero divisor acts as one
    assign w_div      = (r_ticks == '0) ? TPU_W'(1) : r_ticks;
    assign w_half     = w_div >> 1;
    assign w_trial    = {r_rem, r_dividend[DIVD_W-1]};
    assign w_ge       = w_trial >= {1'b0, w_div};
    assign w_diff     = w_trial - {1'b0, w_div};
    assign w_rem_next = w_ge ? w_diff[TPU_W-1:0] : w_trial[TPU_W-1:0];

    assign w_num32   = 32'(r_idx) + 32'd1;
    assign w_tot32   = 32'(r_total);
    assign w_is_last = (w_num32 == w_tot32);

    // Store widths on edge transactions
    always_comb begin
        w_hi_we = 1'b0;
        w_lo_we = 1'b0;
        if (w_in_acc && (i_op == OP_EDGE) && w_room) begin
            if (!r_first_seen) begin
                w_hi_we = !i_pin_level;
            end else if (i_pin_level) begin
                w_lo_we = 1'b1;
            end else begin
                w_hi_we = 1'b1;
            end
        end
    end

    ptwr_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_PULSES)
    ) u_high_ram (
        .i_clk   (i_clk),
        .i_we    (w_hi_we),
        .i_waddr (w_waddr),
        .i_wdata (w_width),
        .i_raddr (w_raddr),
        .o_rdata (w_hi_rdata)
    );

    ptwr_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_PULSES)
    ) u_low_ram (
        .i_clk   (i_clk),
        .i_we    (w_lo_we),
        .i_waddr (w_waddr),
        .i_wdata (w_width),
        .i_raddr (w_raddr),
        .o_rdata (w_lo_rdata)
    );

    // Sequencer: next state and register updates
    always_comb begin
        n_state         = r_state;
        n_first_seen    = r_first_seen;
        n_count         = r_count;
        n_total         = r_total;
        n_idx           = r_idx;
        n_step          = r_step;
        n_last_capture  = r_last_capture;
        n_last_event_ms = r_last_event_ms;
        n_timeout       = r_timeout;
        n_ticks         = r_ticks;
        n_dividend      = r_dividend;
        n_rem           = r_rem;
        n_q_hi          = r_q_hi;
        n_out_num       = r_out_num;
        n_out_high      = r_out_high;
        n_out_low       = r_out_low;
        n_out_total     = r_out_total;
        n_out_last      = r_out_last;
        // drop the held result once the output side takes it
        n_out_valid     = r_out_valid && i_stall;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDLE_TIMEOUT: n_timeout = i_cfg_data[TMO_W-1:0];
                CFG_TICK_RATE:    n_ticks   = i_cfg_data[TPU_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_op == OP_EDGE) begin
                        if (!r_first_seen) begin
                            if (!i_pin_level) begin
                                n_first_seen = 1'b1;
                            end
                        end else if (i_pin_level && w_room) begin
                            n_count = r_count + CW'(1);
                        end
                        n_last_capture  = i_capture_time;
                        n_last_event_ms = i_now_ms;
                    end else if (w_dump) begin
                        // latch the train size, clear the train and start the report
                        n_total      = r_count;
                        n_idx        = '0;
                        n_count      = '0;
                        n_first_seen = 1'b0;
                        n_state      = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD_HI;
            end
            S_LOAD_HI: begin
                n_dividend = {1'b0, w_hi_rdata} + DIVD_W'(w_half);
                n_rem      = '0;
                n_step     = '0;
                n_state    = S_DIV_HI;
            end
            S_DIV_HI: begin
                n_dividend = {r_dividend[DIVD_W-2:0], w_ge};
                n_rem      = w_rem_next;
                n_step     = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_LOAD_LO;
                end
            end
            S_LOAD_LO: begin
                n_q_hi     = r_dividend[TIME_W-1:0];
                n_dividend = {1'b0, w_lo_rdata} + DIVD_W'(w_half);
                n_rem      = '0;
                n_step     = '0;
                n_state    = S_DIV_LO;
            end
            S_DIV_LO: begin
                n_dividend = {r_dividend[DIVD_W-2:0], w_ge};
                n_rem      = w_rem_next;
                n_step     = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_num   = w_num32[NUM_W-1:0];
                    n_out_high  = r_q_hi;
                    n_out_low   = r_dividend[TIME_W-1:0];
                    n_out_total = w_tot32[NUM_W-1:0];
                    n_out_last  = w_is_last;
                    if (w_is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_first_seen    <= 1'b0;
            r_count         <= '0;
            r_total         <= '0;
            r_idx           <= '0;
            r_step          <= '0;
            r_out_valid     <= 1'b0;
            r_last_capture  <= '0;
            r_last_event_ms <= '0;
            r_timeout       <= TMO_RST;
            r_ticks         <= TPU_RST;
        end else begin
            r_state         <= n_state;
            r_first_seen    <= n_first_seen;
            r_count         <= n_count;
            r_total         <= n_total;
            r_idx           <= n_idx;
            r_step          <= n_step;
            r_out_valid     <= n_out_valid;
            r_last_capture  <= n_last_capture;
            r_last_event_ms <= n_last_event_ms;
            r_timeout       <= n_timeout;
            r_ticks         <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dividend  <= n_dividend;
        r_rem       <= n_rem;
        r_q_hi      <= n_q_hi;
        r_out_num   <= n_out_num;
        r_out_high  <= n_out_high;
        r_out_low   <= n_out_low;
        r_out_total <= n_out_total;
        r_out_last  <= n_out_last;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_pulse_number = r_out_num;
    assign o_high_us      = r_out_high;
    assign o_low_us       = r_out_low;
    assign o_total_pulses = r_out_total;
    assign o_last         = r_out_last;

    // The pulse count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PULSES))
        else $error("pulse count above capacity");

    // Pulses are only counted once the train has started
    a_count_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_first_seen |-> (r_count == '0))
        else $error("pulses counted before the first falling edge");

    // The report index stays inside the train being reported
    a_idx_in_train: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx < r_total))
        else $error("report index outside the train");

endmodule
